@@ rtl/core/e2ct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2ct_pkg
// Shared types, constants and small tables for the epoch to calendar converter.
// ----------------------------------------------------------------------------
package e2ct_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DST_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_DST_FIRST_DAY = 2'd1;
    localparam logic [1:0] CFG_DST_LAST_DAY  = 2'd2;

    localparam logic       DST_ENABLE_RESET    = 1'b1;
    localparam logic [8:0] DST_FIRST_DAY_RESET = 9'd69;
    localparam logic [8:0] DST_LAST_DAY_RESET  = 9'd307;

    // Divider phases: reciprocal estimate, remainder, one correction
    localparam logic [1:0] DIV_PHASE_EST = 2'd2;
    localparam logic [1:0] DIV_PHASE_REM = 2'd1;
    localparam logic [1:0] DIV_PHASE_FIX = 2'd0;

    // Estimates land on the quotient or one below it:
    //   days    (secs >> 7) * 49710 >> 25   (86400 = 128 * 675)
    //   hours   (sod >> 4) * 36 >> 13       (3600 = 16 * 225)
    //   minutes (soh >> 2) * 68 >> 10       (60 = 4 * 15)
    localparam logic [15:0] RECIP_DAY  = 16'd49710;
    localparam logic [5:0]  RECIP_HOUR = 6'd36;
    localparam logic [6:0]  RECIP_MIN  = 7'd68;

    localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [17:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [17:0] SECS_PER_MIN  = 18'd60;

    localparam logic [11:0] BASE_YEAR      = 12'd1970;
    localparam logic [6:0]  BASE_YEAR_M100 = 7'd70;
    localparam logic [8:0]  BASE_YEAR_M400 = 9'd370;
    localparam logic [4:0]  BASE_CENTURY   = 5'd19;

    // mod 7 by reciprocal: floor(s * 293 / 2048) == floor(s / 7) for s < 512
    localparam logic [8:0] RECIP7 = 9'd293;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_LOAD_HOUR,
        ST_DIV_HOUR,
        ST_LOAD_MIN,
        ST_DIV_MIN,
        ST_LOAD_SEC,
        ST_YEAR,
        ST_MONTH,
        ST_WEEK,
        ST_FINISH
    } e2ct_state_t;

    typedef enum logic [1:0] {
        DIVISOR_DAY,
        DIVISOR_HOUR,
        DIVISOR_MIN
    } e2ct_div_t;

    typedef struct packed {
        logic      load;
        logic      div_est;
        logic      div_rem;
        logic      div_fix;
        e2ct_div_t div_sel;
        logic      take_day;
        logic      take_hour;
        logic      take_min;
        logic      year_step;
        logic      take_yday;
        logic      month_step;
        logic      week_sum;
        logic      finish;
    } e2ct_cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } e2ct_status_t;

    // Days in month, February of a common year
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // floor(13 * (zm + 1) / 5), January and February as months 13 and 14
    function automatic logic [5:0] zeller_month_term(input logic [3:0] month);
        logic [5:0] v;
        unique case (month)
            4'd1:    v = 6'd36;
            4'd2:    v = 6'd39;
            4'd3:    v = 6'd10;
            4'd4:    v = 6'd13;
            4'd5:    v = 6'd15;
            4'd6:    v = 6'd18;
            4'd7:    v = 6'd20;
            4'd8:    v = 6'd23;
            4'd9:    v = 6'd26;
            4'd10:   v = 6'd28;
            4'd11:   v = 6'd31;
            4'd12:   v = 6'd33;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/e2ct_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2ct_ctrl
// Sequencer: runs the divider stages, year and month walks, weekday and finish.
// ----------------------------------------------------------------------------
module e2ct_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire e2ct_pkg::e2ct_status_t status,
    output e2ct_pkg::e2ct_cmd_t        cmd,
    output logic                       busy,
    output logic                       done
);

    e2ct_pkg::e2ct_state_t state_reg, state_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= e2ct_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.div_sel = e2ct_pkg::DIVISOR_DAY;
        unique case (state_reg)
            e2ct_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = e2ct_pkg::DIV_PHASE_EST;
                    state_next = e2ct_pkg::ST_DIV_DAY;
                end
            end
            e2ct_pkg::ST_DIV_DAY:
            begin
                cmd.div_sel = e2ct_pkg::DIVISOR_DAY;
                cmd.div_est = (cnt_reg == e2ct_pkg::DIV_PHASE_EST);
                cmd.div_rem = (cnt_reg == e2ct_pkg::DIV_PHASE_REM);
                cmd.div_fix = (cnt_reg == e2ct_pkg::DIV_PHASE_FIX);
                cnt_next    = cnt_reg - 2'd1;
                if (cnt_reg == e2ct_pkg::DIV_PHASE_FIX)
                    state_next = e2ct_pkg::ST_LOAD_HOUR;
            end
            e2ct_pkg::ST_LOAD_HOUR:
            begin
                cmd.take_day = 1'b1;
                cnt_next     = e2ct_pkg::DIV_PHASE_EST;
                state_next   = e2ct_pkg::ST_DIV_HOUR;
            end
            e2ct_pkg::ST_DIV_HOUR:
            begin
                cmd.div_sel = e2ct_pkg::DIVISOR_HOUR;
                cmd.div_est = (cnt_reg == e2ct_pkg::DIV_PHASE_EST);
                cmd.div_rem = (cnt_reg == e2ct_pkg::DIV_PHASE_REM);
                cmd.div_fix = (cnt_reg == e2ct_pkg::DIV_PHASE_FIX);
                cnt_next    = cnt_reg - 2'd1;
                if (cnt_reg == e2ct_pkg::DIV_PHASE_FIX)
                    state_next = e2ct_pkg::ST_LOAD_MIN;
            end
            e2ct_pkg::ST_LOAD_MIN:
            begin
                cmd.take_hour = 1'b1;
                cnt_next      = e2ct_pkg::DIV_PHASE_EST;
                state_next    = e2ct_pkg::ST_DIV_MIN;
            end
            e2ct_pkg::ST_DIV_MIN:
            begin
                cmd.div_sel = e2ct_pkg::DIVISOR_MIN;
                cmd.div_est = (cnt_reg == e2ct_pkg::DIV_PHASE_EST);
                cmd.div_rem = (cnt_reg == e2ct_pkg::DIV_PHASE_REM);
                cmd.div_fix = (cnt_reg == e2ct_pkg::DIV_PHASE_FIX);
                cnt_next    = cnt_reg - 2'd1;
                if (cnt_reg == e2ct_pkg::DIV_PHASE_FIX)
                    state_next = e2ct_pkg::ST_LOAD_SEC;
            end
            e2ct_pkg::ST_LOAD_SEC:
            begin
                cmd.take_min = 1'b1;
                state_next   = e2ct_pkg::ST_YEAR;
            end
            e2ct_pkg::ST_YEAR:
            begin
                if (status.year_fit)
                begin
                    cmd.take_yday = 1'b1;
                    state_next    = e2ct_pkg::ST_MONTH;
                end
                else
                    cmd.year_step = 1'b1;
            end
            e2ct_pkg::ST_MONTH:
            begin
                if (status.month_fit)
                begin
                    cmd.week_sum = 1'b1;
                    state_next   = e2ct_pkg::ST_WEEK;
                end
                else
                    cmd.month_step = 1'b1;
            end
            e2ct_pkg::ST_WEEK:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = e2ct_pkg::ST_FINISH;
            end
            e2ct_pkg::ST_FINISH:
            begin
                state_next = e2ct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = e2ct_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != e2ct_pkg::ST_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

@@ rtl/core/e2ct_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2ct_datapath
// Reciprocal dividers, year/month walk counters, DST window and weekday logic.
// ----------------------------------------------------------------------------
module e2ct_datapath (
    input  wire logic                  clk,
    input  wire e2ct_pkg::e2ct_cmd_t   cmd,
    output e2ct_pkg::e2ct_status_t     status,
    input  wire logic [31:0]           epoch_seconds,
    input  wire logic                  dst_enable,
    input  wire logic [8:0]            dst_first_day,
    input  wire logic [8:0]            dst_last_day,
    output logic [5:0]                 second_of_minute,
    output logic [5:0]                 minute_of_hour,
    output logic [4:0]                 hour_of_day,
    output logic [4:0]                 day_of_month,
    output logic [3:0]                 month_number,
    output logic [11:0]                year_number,
    output logic [2:0]                 weekday_number,
    output logic                       dst_active
);

    // divider: reciprocal estimate, remainder, one correction
    logic [31:0] num_reg, num_next;
    logic [17:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [17:0] divisor;
    logic [40:0] day_prod;
    logic [18:0] hour_prod;
    logic [16:0] min_prod;
    logic [15:0] quo_est;
    logic [33:0] back_prod;
    logic [31:0] rem_full;

    // time and calendar working state
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [15:0] days_reg, days_next;
    logic [8:0]  yday_reg, yday_next;
    logic [11:0] year_reg, year_next;
    logic [6:0]  ym100_reg, ym100_next;
    logic [8:0]  ym400_reg, ym400_next;
    logic [4:0]  cent_reg, cent_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  dom_reg, dom_next;
    logic        dst_reg, dst_next;
    logic [8:0]  wsum_reg, wsum_next;

    // outputs
    logic [5:0]  sec_out_reg, min_out_reg;
    logic [4:0]  hour_out_reg, dom_out_reg;
    logic [3:0]  month_out_reg;
    logic [11:0] year_out_reg;
    logic [2:0]  wd_out_reg;
    logic        dst_out_reg;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [9:0]  win_lo, win_hi;
    logic        in_window;
    logic [6:0]  zk;
    logic [4:0]  zj;
    logic [17:0] wprod;
    logic [8:0]  wquot;
    logic [8:0]  wrem;

    // estimate is the quotient or one below it
    assign day_prod  = 41'(num_reg[31:7]) * 41'(e2ct_pkg::RECIP_DAY);
    assign hour_prod = 19'(num_reg[16:4]) * 19'(e2ct_pkg::RECIP_HOUR);
    assign min_prod  = 17'(num_reg[11:2]) * 17'(e2ct_pkg::RECIP_MIN);

    always_comb begin
        unique case (cmd.div_sel)
            e2ct_pkg::DIVISOR_DAY:
            begin
                divisor = e2ct_pkg::SECS_PER_DAY;
                quo_est = day_prod[40:25];
            end
            e2ct_pkg::DIVISOR_HOUR:
            begin
                divisor = e2ct_pkg::SECS_PER_HOUR;
                quo_est = {10'd0, hour_prod[18:13]};
            end
            e2ct_pkg::DIVISOR_MIN:
            begin
                divisor = e2ct_pkg::SECS_PER_MIN;
                quo_est = {9'd0, min_prod[16:10]};
            end
            default:
            begin
                divisor = e2ct_pkg::SECS_PER_DAY;
                quo_est = day_prod[40:25];
            end
        endcase
    end

    // remainder is below twice the divisor, so 18 bits hold it
    assign back_prod = 34'(quo_reg) * 34'(divisor);
    assign rem_full  = num_reg - back_prod[31:0];

    assign leap = ((year_reg[1:0] == 2'd0) && (ym100_reg != 7'd0)) || (ym400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = ((month_reg == 4'd2) && leap) ? 5'd29 : e2ct_pkg::month_days(month_reg);

    assign status.year_fit  = (days_reg < {7'd0, ylen});
    assign status.month_fit = (days_reg < {11'd0, mlen}) || (month_reg == 4'd12);

    // window bounds shift by one day in leap years
    assign win_lo    = {1'b0, dst_first_day} + {9'd0, leap};
    assign win_hi    = {1'b0, dst_last_day} + {9'd0, leap};
    assign in_window = dst_enable && ({1'b0, yday_reg} >= win_lo)
                       && ({1'b0, yday_reg} <= win_hi);

    // January and February belong to the previous year
    always_comb begin
        zk = ym100_reg;
        zj = cent_reg;
        if (month_reg < 4'd3)
        begin
            if (ym100_reg == 7'd0)
            begin
                zk = 7'd99;
                zj = cent_reg - 5'd1;
            end
            else
                zk = ym100_reg - 7'd1;
        end
    end

    assign wprod = 18'(wsum_reg) * 18'(e2ct_pkg::RECIP7);
    assign wquot = {2'd0, wprod[17:11]};
    assign wrem  = wsum_reg - ((wquot << 3) - wquot);

    always_comb begin
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        days_next  = days_reg;
        yday_next  = yday_reg;
        year_next  = year_reg;
        ym100_next = ym100_reg;
        ym400_next = ym400_reg;
        cent_next  = cent_reg;
        month_next = month_reg;
        dom_next   = dom_reg;
        dst_next   = dst_reg;
        wsum_next  = wsum_reg;

        if (cmd.load)
        begin
            num_next   = epoch_seconds;
            year_next  = e2ct_pkg::BASE_YEAR;
            ym100_next = e2ct_pkg::BASE_YEAR_M100;
            ym400_next = e2ct_pkg::BASE_YEAR_M400;
            cent_next  = e2ct_pkg::BASE_CENTURY;
            month_next = 4'd1;
        end

        if (cmd.div_est)
            quo_next = quo_est;

        if (cmd.div_rem)
            rem_next = rem_full[17:0];

        if (cmd.div_fix && (rem_reg >= divisor))
        begin
            quo_next = quo_reg + 16'd1;
            rem_next = rem_reg - divisor;
        end

        if (cmd.take_day)
        begin
            days_next = quo_reg;
            num_next  = {14'd0, rem_reg};
        end

        if (cmd.take_hour)
        begin
            hour_next = quo_reg[4:0];
            num_next  = {14'd0, rem_reg};
        end

        if (cmd.take_min)
        begin
            min_next = quo_reg[5:0];
            sec_next = rem_reg[5:0];
        end

        if (cmd.year_step)
        begin
            days_next  = days_reg - {7'd0, ylen};
            year_next  = year_reg + 12'd1;
            ym100_next = (ym100_reg == 7'd99) ? 7'd0 : ym100_reg + 7'd1;
            cent_next  = (ym100_reg == 7'd99) ? cent_reg + 5'd1 : cent_reg;
            ym400_next = (ym400_reg == 9'd399) ? 9'd0 : ym400_reg + 9'd1;
        end

        if (cmd.take_yday)
            yday_next = days_reg[8:0];

        if (cmd.month_step)
        begin
            days_next  = days_reg - {11'd0, mlen};
            month_next = month_reg + 4'd1;
        end

        if (cmd.week_sum)
        begin
            dom_next  = days_reg[4:0] + 5'd1;
            dst_next  = in_window;
            wsum_next = 9'(days_reg[4:0]) + 9'd1
                        + 9'(e2ct_pkg::zeller_month_term(month_reg))
                        + 9'(zk) + 9'(zk[6:2]) + 9'(zj[4:2])
                        + 9'({zj, 2'b00}) + 9'(zj);
        end
    end

    always_ff @(posedge clk) begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        days_reg  <= days_next;
        yday_reg  <= yday_next;
        year_reg  <= year_next;
        ym100_reg <= ym100_next;
        ym400_reg <= ym400_next;
        cent_reg  <= cent_next;
        month_reg <= month_next;
        dom_reg   <= dom_next;
        dst_reg   <= dst_next;
        wsum_reg  <= wsum_next;
        if (cmd.finish)
        begin
            sec_out_reg   <= sec_reg;
            min_out_reg   <= min_reg;
            hour_out_reg  <= hour_reg + {4'd0, dst_reg};
            dom_out_reg   <= dom_reg;
            month_out_reg <= month_reg;
            year_out_reg  <= year_reg;
            wd_out_reg    <= wrem[2:0];
            dst_out_reg   <= dst_reg;
        end
    end

    assign second_of_minute = sec_out_reg;
    assign minute_of_hour   = min_out_reg;
    assign hour_of_day      = hour_out_reg;
    assign day_of_month     = dom_out_reg;
    assign month_number     = month_out_reg;
    assign year_number      = year_out_reg;
    assign weekday_number   = wd_out_reg;
    assign dst_active       = dst_out_reg;

endmodule
`default_nettype wire

@@ rtl/core/epoch_to_calendar_time.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar_time
// Local epoch seconds to time of day, Gregorian date, weekday and DST flag.
// ----------------------------------------------------------------------------
// A conversion begins at the clock edge where start is high and busy is low.
// Days, hours and minutes are each split off by a reciprocal-multiply
// estimate, a remainder and one correction, each with a load step; then the
// years are walked from 1970 (up to 135 for a date that also walks a full
// year of months), the months (up to 11), each walk with a closing step,
// and the weekday is formed. done is high in the cycle after the weekday
// step, with the outputs updated. busy stays high through that cycle, so
// the next start is taken at the edge after it. The receiver cannot stall,
// so it must take the transfer in that cycle. The outputs keep their values
// until the next conversion ends. hour_of_day includes the DST hour and can
// read 24; the date is not advanced for it. The weekday comes from Zeller's
// congruence with 0 meaning Saturday. Configuration writes take effect at
// once; the user must make them only while no conversion is in progress,
// as the block does not enforce it: index 0 dst_enable, 1 dst_first_day,
// 2 dst_last_day; other indexes are ignored.
// ----------------------------------------------------------------------------
module epoch_to_calendar_time (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] epoch_seconds,
    // configuration write port
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // result transfer
    output logic             done,
    output logic [5:0]       second_of_minute,
    output logic [5:0]       minute_of_hour,
    output logic [4:0]       hour_of_day,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_number,
    output logic [11:0]      year_number,
    output logic [2:0]       weekday_number,
    output logic             dst_active
);

    // DST window registers
    logic       dst_enable_reg;
    logic [8:0] dst_first_reg;
    logic [8:0] dst_last_reg;

    e2ct_pkg::e2ct_cmd_t    cmd;
    e2ct_pkg::e2ct_status_t status;
    logic                   busy_int;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            dst_enable_reg <= e2ct_pkg::DST_ENABLE_RESET;
            dst_first_reg  <= e2ct_pkg::DST_FIRST_DAY_RESET;
            dst_last_reg   <= e2ct_pkg::DST_LAST_DAY_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                e2ct_pkg::CFG_DST_ENABLE:    dst_enable_reg <= cfg_data[0];
                e2ct_pkg::CFG_DST_FIRST_DAY: dst_first_reg  <= cfg_data;
                e2ct_pkg::CFG_DST_LAST_DAY:  dst_last_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // sequencer: issues one command set per cycle
    e2ct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy_int),
        .done   (done)
    );

    // divider, calendar walk and weekday arithmetic
    e2ct_datapath u_datapath (
        .clk              (clk),
        .cmd              (cmd),
        .status           (status),
        .epoch_seconds    (epoch_seconds),
        .dst_enable       (dst_enable_reg),
        .dst_first_day    (dst_first_reg),
        .dst_last_day     (dst_last_reg),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_number     (month_number),
        .year_number      (year_number),
        .weekday_number   (weekday_number),
        .dst_active       (dst_active)
    );

    assign busy = busy_int;

endmodule
`default_nettype wire
